/* src/bq_pkg.sv */
// shared types, constants and arithmetic helpers of the biquad response block
// no dependencies

package bq_pkg;

	localparam int CORDIC_STEPS   = 24;
	localparam int COEF_FRAC_BITS = 26;
	localparam int CIDX_W         = 5;

	localparam logic signed [65:0] K_Q30      = 66'sd652032874;
	localparam logic signed [32:0] PI_Q30     = 33'sd3373259426;
	localparam logic signed [34:0] PI_HALF    = 35'sd1686629713;
	localparam logic signed [30:0] PI_Q28     = 31'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q23 = 34'sd52707179;
	localparam logic signed [33:0] THRESH_Q23 = 34'sd39530384;
	localparam logic signed [65:0] ONE_DEN    = 66'sd1 <<< (COEF_FRAC_BITS + 30);

	// register indexes of the configuration port
	localparam logic [2:0] REG_B0   = 3'd0;
	localparam logic [2:0] REG_B1   = 3'd1;
	localparam logic [2:0] REG_B2   = 3'd2;
	localparam logic [2:0] REG_A1   = 3'd3;
	localparam logic [2:0] REG_A2   = 3'd4;
	localparam logic [2:0] REG_STOP = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_TDIV, S_MUL, S_ROT, S_ZCHK, S_NORM, S_NSHIFT, S_SQN, S_SQD,
		S_DIVR, S_DIVI, S_DIVM, S_ATAN, S_UNW1, S_UNW2, S_UNW3, S_DONE
	} bq_state_t;

	// command to the cordic unit
	typedef struct packed {
		logic start;
		logic vectoring;
	} bq_cordic_cmd_t;

	// arctangent table, floor(atan(2^-i) * 2^30)
	function automatic logic [29:0] atan_q30(input logic [CIDX_W-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314856;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525158;
			5'd4:  v = 30'd67021686;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775850;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194282;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			5'd24: v = 30'd63;
			5'd25: v = 30'd31;
			5'd26: v = 30'd15;
			5'd27: v = 30'd7;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [63:0] uabs64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// power of two scaling with rounding on the right shift
	function automatic logic signed [31:0] norm_shift(input logic signed [63:0] v,
		input logic signed [7:0] s);
		logic signed [64:0] t;
		int sh;
		sh = int'(s);
		t = {v[63], v};
		if (sh > 0)
			t = (t + (65'sd1 <<< (sh - 1))) >>> sh;
		else if (sh < 0)
			t = t <<< (-sh);
		return t[31:0];
	endfunction

	// quotient with 40 fraction bits scaled by 2^k, rounded and limited
	function automatic logic [32:0] scale_u(input logic [63:0] v, input logic signed [8:0] k,
		input logic [32:0] limit);
		logic [63:0] t;
		logic [32:0] r;
		int kk;
		kk = int'(k);
		t = 64'd0;
		if (v == 64'd0)
			r = 33'd0;
		else if (kk >= 0) begin
			if (kk >= 40)
				r = limit;
			else if (v > ({31'd0, limit} >> kk))
				r = limit;
			else begin
				t = v << kk;
				r = t[32:0];
			end
		end else if (-kk >= 50)
			r = 33'd0;
		else begin
			t = (v + (64'd1 << (-kk - 1))) >> (-kk);
			r = (t > {31'd0, limit}) ? limit : t[32:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] signed_out(input logic neg, input logic [63:0] q,
		input logic signed [8:0] k);
		logic [32:0] mag;
		mag = scale_u(q, k, neg ? 33'h1_0000_0000 - 33'h0_8000_0000 : 33'h0_7FFF_FFFF);
		return neg ? 32'(-mag) : mag[31:0];
	endfunction

endpackage

/* src/biquad_response_with_unwrap.sv */
// Biquad frequency response evaluator with phase unwrapping. One frequency point
// is taken at a time and the input stalls until it is finished. A regular item runs
// the frequency to angle division, the sine/cosine pass of the cordic, twenty
// products on the shared multiplier, the normalization bit scan, the two square
// roots, the three fraction divisions and the atan2 pass of the cordic. The
// divider, the square root unit and the normalization scan take most of its time.
// A point with a zero numerator or a zero denominator skips normalization, the
// square roots, division and atan2. A finished result waits in the output
// register while the next point is accepted.
// depends on bq_pkg, bq_mul, bq_cordic, bq_div, bq_sqrt

module biquad_response_with_unwrap import bq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        frequency,
	input  logic               first_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] response_real,
	output logic signed [31:0] response_imag,
	output logic [31:0]        magnitude,
	output logic signed [30:0] wrapped_phase,
	output logic signed [31:0] unwrapped_phase,
	output logic               zero_denominator
);

	bq_state_t state_q, state_d;

	logic signed [31:0] coef_q [5];
	logic [23:0]        stop_q;

	logic               ph_q;
	logic [4:0]         op_q;
	logic [23:0]        f_q;
	logic               first_q;
	logic [1:0]         quad_q;
	logic signed [31:0] r_q;
	logic signed [34:0] ang_q;
	logic signed [32:0] zr_q, zi_q, zr2_q, zi2_q;
	logic signed [65:0] acc_q;
	logic signed [63:0] nr_q, ni_q, dr_q, di_q;
	logic [63:0]        mn_q, md_q;
	logic [6:0]         lenn_q, lend_q;
	logic signed [31:0] nrs_q, nis_q, drs_q, dis_q;
	logic signed [8:0]  k_q;
	logic signed [63:0] pr_q, pim_q;
	logic [63:0]        den_q, nn_q;
	logic [31:0]        sn_q, sd_q;
	logic [31:0]        real_q, imag_q, mag_q;
	logic signed [30:0] w_q;
	logic signed [31:0] p23_q, corr_q, off_q, prev_q;
	logic               zden_q;
	logic               out_valid_q;

	// unit hookup
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	bq_cordic_cmd_t     cor_cmd;
	logic signed [65:0] cor_x0, cor_y0, cor_x, cor_y;
	logic signed [34:0] cor_z0, cor_z;
	logic               cor_done;
	logic               div_start, div_done;
	logic [63:0]        div_rem0, div_dvd, div_quo;
	logic [66:0]        div_den;
	logic [5:0]         div_steps;
	logic               sq_start, sq_done;
	logic [63:0]        sq_n;
	logic [31:0]        sq_root;
	logic               unit_done;

	// helpers
	logic [23:0]        stop_eff;
	logic [31:0]        t_w, u_w;
	logic [1:0]         q_w;
	logic signed [65:0] wb_sum, wb_dif, z2_w;
	logic signed [32:0] w33;
	logic signed [33:0] c1_w, d_w;
	logic               adj_w;
	logic               den_zero, num_zero;
	logic signed [7:0]  gs_w, es_w;
	logic               in_xfer, out_free;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign stop_eff = (stop_q == 24'd0) ? 24'd1 : stop_q;

	bq_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	bq_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd),
		.x0     (cor_x0),
		.y0     (cor_y0),
		.z0     (cor_z0),
		.done   (cor_done),
		.x      (cor_x),
		.y      (cor_y),
		.z      (cor_z)
	);

	bq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rem0   (div_rem0),
		.dvd    (div_dvd),
		.den    (div_den),
		.steps  (div_steps),
		.done   (div_done),
		.quo    (div_quo)
	);

	bq_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (sq_n),
		.done   (sq_done),
		.root   (sq_root)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= 32'sd67108864;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			coef_q[3] <= '0;
			coef_q[4] <= '0;
			stop_q    <= 24'd384000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:   coef_q[0] <= cfg_data;
				REG_B1:   coef_q[1] <= cfg_data;
				REG_B2:   coef_q[2] <= cfg_data;
				REG_A1:   coef_q[3] <= cfg_data;
				REG_A2:   coef_q[4] <= cfg_data;
				REG_STOP: stop_q    <= cfg_data[23:0];
				default:  ;
			endcase
		end
	end

	// combinational datapath pieces
	always_comb begin
		t_w      = div_quo[31:0];
		q_w      = 2'((t_w + 32'h2000_0000) >> 30);
		u_w      = t_w - {q_w, 30'd0};
		wb_sum   = acc_q + mul_p;
		wb_dif   = acc_q - mul_p;
		z2_w     = mul_p <<< 1;
		w33      = (cor_z + 35'sd2) >>> 2 > 35'(PI_Q28) ? 33'(PI_Q28) :
			((cor_z + 35'sd2) >>> 2 < -35'(PI_Q28) ? -33'(PI_Q28) :
			33'((cor_z + 35'sd2) >>> 2));
		c1_w     = 34'(sat32(34'(p23_q) + 34'(off_q)));
		d_w      = 34'(prev_q) - c1_w;
		adj_w    = !first_q && (d_w > THRESH_Q23 || d_w < -THRESH_Q23);
		den_zero = (dr_q == 64'sd0) && (di_q == 64'sd0);
		num_zero = (nr_q == 64'sd0) && (ni_q == 64'sd0);
		gs_w     = $signed({1'b0, lenn_q}) - 8'sd30;
		es_w     = $signed({1'b0, lend_q}) - 8'sd30;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_xfer) state_d = S_TDIV;
			S_TDIV:   if (ph_q && unit_done) state_d = S_MUL;
			S_MUL: begin
				if (ph_q) begin
					if (op_q == 5'd0)
						state_d = S_ROT;
					else if (op_q == 5'd11)
						state_d = S_ZCHK;
					else if (op_q == 5'd19)
						state_d = S_SQN;
				end
			end
			S_ROT:    if (ph_q && unit_done) state_d = S_MUL;
			S_ZCHK: begin
				if (den_zero)
					state_d = S_DONE;
				else if (num_zero)
					state_d = S_UNW1;
				else
					state_d = S_NORM;
			end
			S_NORM:   if (mn_q == 64'd0 && md_q == 64'd0) state_d = S_NSHIFT;
			S_NSHIFT: state_d = S_MUL;
			S_SQN:    if (ph_q && unit_done) state_d = S_SQD;
			S_SQD:    if (ph_q && unit_done) state_d = S_DIVR;
			S_DIVR:   if (ph_q && unit_done) state_d = S_DIVI;
			S_DIVI:   if (ph_q && unit_done) state_d = S_DIVM;
			S_DIVM:   if (ph_q && unit_done) state_d = S_ATAN;
			S_ATAN:   if (ph_q && unit_done) state_d = S_UNW1;
			S_UNW1:   state_d = S_UNW2;
			S_UNW2:   state_d = adj_w ? S_UNW3 : S_DONE;
			S_UNW3:   state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// unit commands and operand selection
	always_comb begin
		in_stall          = (state_q != S_IDLE);
		cor_cmd.start     = 1'b0;
		cor_cmd.vectoring = 1'b0;
		cor_x0            = K_Q30;
		cor_y0            = '0;
		cor_z0            = ang_q;
		div_start         = 1'b0;
		div_rem0          = '0;
		div_dvd           = '0;
		div_den           = {43'd0, stop_eff};
		div_steps         = 6'd55;
		sq_start          = 1'b0;
		sq_n              = nn_q;
		unit_done         = 1'b0;
		mul_a             = '0;
		mul_b             = '0;
		unique case (state_q)
			S_TDIV: begin
				div_start = !ph_q;
				div_dvd   = {f_q, 40'd0};
				unit_done = div_done;
			end
			S_ROT: begin
				cor_cmd.start = !ph_q;
				unit_done     = cor_done;
			end
			S_SQN: begin
				sq_start  = !ph_q;
				unit_done = sq_done;
			end
			S_SQD: begin
				sq_start  = !ph_q;
				sq_n      = den_q;
				unit_done = sq_done;
			end
			S_DIVR, S_DIVI: begin
				div_start = !ph_q;
				div_rem0  = uabs64((state_q == S_DIVR) ? pr_q : pim_q);
				div_den   = {den_q[62:0], 4'd0};
				div_steps = 6'd44;
				unit_done = div_done;
			end
			S_DIVM: begin
				div_start = !ph_q;
				div_rem0  = {32'd0, sn_q};
				div_den   = {31'd0, sd_q, 4'd0};
				div_steps = 6'd44;
				unit_done = div_done;
			end
			S_ATAN: begin
				cor_cmd.start     = !ph_q;
				cor_cmd.vectoring = 1'b1;
				unit_done         = cor_done;
				if (pr_q[63]) begin
					if (!pim_q[63]) begin
						cor_x0 = 66'(pim_q);
						cor_y0 = -66'(pr_q);
						cor_z0 = PI_HALF;
					end else begin
						cor_x0 = -66'(pim_q);
						cor_y0 = 66'(pr_q);
						cor_z0 = -PI_HALF;
					end
				end else begin
					cor_x0 = 66'(pr_q);
					cor_y0 = 66'(pim_q);
					cor_z0 = '0;
				end
			end
			S_MUL: begin
				case (op_q)
					5'd0:  begin mul_a = 33'(r_q);     mul_b = PI_Q30; end
					5'd1:  begin mul_a = zr_q;         mul_b = zr_q;   end
					5'd2:  begin mul_a = zi_q;         mul_b = zi_q;   end
					5'd3:  begin mul_a = zr_q;         mul_b = zi_q;   end
					5'd4:  begin mul_a = 33'(coef_q[1]); mul_b = zr_q;  end
					5'd5:  begin mul_a = 33'(coef_q[2]); mul_b = zr2_q; end
					5'd6:  begin mul_a = 33'(coef_q[1]); mul_b = zi_q;  end
					5'd7:  begin mul_a = 33'(coef_q[2]); mul_b = zi2_q; end
					5'd8:  begin mul_a = 33'(coef_q[3]); mul_b = zr_q;  end
					5'd9:  begin mul_a = 33'(coef_q[4]); mul_b = zr2_q; end
					5'd10: begin mul_a = 33'(coef_q[3]); mul_b = zi_q;  end
					5'd11: begin mul_a = 33'(coef_q[4]); mul_b = zi2_q; end
					5'd12: begin mul_a = 33'(nrs_q);   mul_b = 33'(drs_q); end
					5'd13: begin mul_a = 33'(nis_q);   mul_b = 33'(dis_q); end
					5'd14: begin mul_a = 33'(nis_q);   mul_b = 33'(drs_q); end
					5'd15: begin mul_a = 33'(nrs_q);   mul_b = 33'(dis_q); end
					5'd16: begin mul_a = 33'(drs_q);   mul_b = 33'(drs_q); end
					5'd17: begin mul_a = 33'(dis_q);   mul_b = 33'(dis_q); end
					5'd18: begin mul_a = 33'(nrs_q);   mul_b = 33'(nrs_q); end
					5'd19: begin mul_a = 33'(nis_q);   mul_b = 33'(nis_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			op_q        <= '0;
			off_q       <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					ph_q <= 1'b0;
					op_q <= '0;
				end
				S_MUL: begin
					ph_q <= !ph_q;
					if (ph_q)
						op_q <= op_q + 1'b1;
				end
				S_TDIV, S_ROT, S_SQN, S_SQD, S_DIVR, S_DIVI, S_DIVM, S_ATAN: begin
					if (!ph_q)
						ph_q <= 1'b1;
					else if (unit_done)
						ph_q <= 1'b0;
				end
				S_ZCHK: begin
					if (first_q) begin
						off_q  <= '0;
						prev_q <= '0;
					end
				end
				S_UNW2: begin
					if (adj_w)
						off_q <= sat32(34'(off_q) + (d_w[33] ? -TWO_PI_Q23 : TWO_PI_Q23));
					else
						prev_q <= c1_w[31:0];
				end
				S_UNW3: prev_q <= sat32(34'(p23_q) + 34'(off_q));
				default: ;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					f_q     <= frequency;
					first_q <= first_point;
					zden_q  <= 1'b0;
				end
			end
			S_TDIV: begin
				if (ph_q && div_done) begin
					quad_q <= q_w;
					r_q    <= $signed(u_w);
				end
			end
			S_ROT: begin
				if (ph_q && cor_done) begin
					case (quad_q)
						2'd0: begin zr_q <= cor_x[32:0];  zi_q <= -cor_y[32:0]; end
						2'd1: begin zr_q <= -cor_y[32:0]; zi_q <= -cor_x[32:0]; end
						2'd2: begin zr_q <= -cor_x[32:0]; zi_q <= cor_y[32:0];  end
						default: begin zr_q <= cor_y[32:0]; zi_q <= cor_x[32:0]; end
					endcase
				end
			end
			S_MUL: begin
				if (ph_q) begin
					case (op_q)
						5'd0:  ang_q <= 35'((mul_p + (66'sd1 <<< 30)) >>> 31);
						5'd2:  zr2_q <= 33'((wb_dif + (66'sd1 <<< 29)) >>> 30);
						5'd3:  zi2_q <= 33'((z2_w + (66'sd1 <<< 29)) >>> 30);
						5'd4:  acc_q <= (66'(coef_q[0]) <<< 30) + mul_p;
						5'd5:  nr_q  <= wb_sum[63:0];
						5'd7:  ni_q  <= wb_sum[63:0];
						5'd8:  acc_q <= ONE_DEN + mul_p;
						5'd9:  dr_q  <= wb_sum[63:0];
						5'd11: di_q  <= wb_sum[63:0];
						5'd13: pr_q  <= wb_sum[63:0];
						5'd15: pim_q <= wb_dif[63:0];
						5'd17: den_q <= wb_sum[63:0];
						5'd19: nn_q  <= wb_sum[63:0];
						default: acc_q <= mul_p;
					endcase
				end
			end
			S_ZCHK: begin
				mn_q   <= uabs64(nr_q) | uabs64(ni_q);
				md_q   <= uabs64(dr_q) | uabs64(di_q);
				lenn_q <= '0;
				lend_q <= '0;
				if (den_zero) begin
					real_q <= 32'h7FFF_FFFF;
					imag_q <= '0;
					mag_q  <= 32'hFFFF_FFFF;
					w_q    <= '0;
					corr_q <= '0;
					zden_q <= 1'b1;
				end else if (num_zero) begin
					real_q <= '0;
					imag_q <= '0;
					mag_q  <= '0;
					w_q    <= '0;
				end
			end
			// bit length scan of both operand pairs
			S_NORM: begin
				if (mn_q != 64'd0) begin
					mn_q   <= mn_q >> 1;
					lenn_q <= lenn_q + 1'b1;
				end
				if (md_q != 64'd0) begin
					md_q   <= md_q >> 1;
					lend_q <= lend_q + 1'b1;
				end
			end
			S_NSHIFT: begin
				nrs_q <= norm_shift(nr_q, gs_w);
				nis_q <= norm_shift(ni_q, gs_w);
				drs_q <= norm_shift(dr_q, es_w);
				dis_q <= norm_shift(di_q, es_w);
				k_q   <= 9'(gs_w) - 9'(es_w) - 9'sd16;
			end
			S_SQN:  if (ph_q && sq_done) sn_q <= sq_root;
			S_SQD:  if (ph_q && sq_done) sd_q <= sq_root;
			S_DIVR: if (ph_q && div_done) real_q <= signed_out(pr_q[63], div_quo, k_q);
			S_DIVI: if (ph_q && div_done) imag_q <= signed_out(pim_q[63], div_quo, k_q);
			S_DIVM: begin
				if (ph_q && div_done)
					mag_q <= 32'(scale_u(div_quo, k_q, 33'h0_FFFF_FFFF));
			end
			S_ATAN: if (ph_q && cor_done) w_q <= w33[30:0];
			S_UNW1: p23_q <= 32'((33'(w_q) + 33'sd16) >>> 5);
			S_UNW2: if (!adj_w) corr_q <= c1_w[31:0];
			S_UNW3: corr_q <= sat32(34'(p23_q) + 34'(off_q));
			S_DONE: begin
				if (out_free) begin
					response_real    <= real_q;
					response_imag    <= imag_q;
					magnitude        <= mag_q;
					wrapped_phase    <= w_q;
					unwrapped_phase  <= corr_q;
					zero_denominator <= zden_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_TDIV)
		else $error("accepted item did not start the angle division");

	a_zden_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_denominator |->
			response_imag == 32'sd0 && wrapped_phase == 31'sd0 && magnitude == 32'hFFFF_FFFF)
		else $error("zero denominator result not saturated");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wrapped_phase <= PI_Q28 && wrapped_phase >= -PI_Q28)
		else $error("wrapped phase out of range");

	a_cordic_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == S_ROT || state_q == S_ATAN)
		else $error("cordic finished outside its sequencer steps");

endmodule

/* src/bq_mul.sv */
// shared signed multiplier with a registered product
// uses nothing beyond the language

module bq_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);

	logic signed [65:0] p_s1;

	// one product per cycle
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	assign p = p_s1;

endmodule

/* src/bq_cordic.sv */
// iterative cordic, rotation mode for sin and cos, vectoring mode for atan2
// depends on bq_pkg

module bq_cordic import bq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  bq_cordic_cmd_t     cmd,
	input  logic signed [65:0] x0,
	input  logic signed [65:0] y0,
	input  logic signed [34:0] z0,
	output logic               done,
	output logic signed [65:0] x,
	output logic signed [65:0] y,
	output logic signed [34:0] z
);

	logic              busy_q;
	logic              done_q;
	logic              vec_q;
	logic [CIDX_W-1:0] i_q;
	logic signed [65:0] x_q, y_q;
	logic signed [34:0] z_q;
	logic signed [65:0] xs, ys;
	logic signed [34:0] at;
	logic               dir;

	// one micro-rotation
	always_comb begin
		xs  = x_q >>> i_q;
		ys  = y_q >>> i_q;
		at  = $signed({5'd0, atan_q30(i_q)});
		dir = vec_q ? y_q[65] : !z_q[34];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == CIDX_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= cmd.vectoring;
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

/* src/bq_div.sv */
// restoring divider, one quotient bit per cycle
// integer or fraction quotient depending on the loaded operands; no package use

module bq_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rem0,
	input  logic [63:0] dvd,
	input  logic [66:0] den,
	input  logic [5:0]  steps,
	output logic        done,
	output logic [63:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [67:0] rem_q;
	logic [66:0] den_q;
	logic [63:0] dvd_q;
	logic [63:0] quo_q;
	logic [67:0] r2;
	logic        ge;

	// shift in the next dividend bit and compare
	always_comb begin
		r2 = {rem_q[66:0], dvd_q[63]};
		ge = r2 >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {4'd0, rem0};
			den_q <= den;
			dvd_q <= dvd;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r2 - {1'b0, den_q} : r2;
			dvd_q <= {dvd_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* src/bq_sqrt.sv */
// floor integer square root, two radicand bits per cycle
// no package use

module bq_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;
	logic        ge;

	always_comb begin
		trial = res_q + bit_q;
		ge    = n_q >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else
				res_q <= res_q >> 1;
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule
